[sv/assert_macros.svh]
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define DMWE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dmwe assertion failed");

// Signal must hold its value in the cycle after the condition
`define DMWE_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("dmwe signal not held");

`endif

[sv/dmwe_pkg.sv]
// Types and constants of the minimum-weight model evaluator
package dmwe_pkg;

  typedef enum logic [1:0] {
    ACT_NODE   = 2'd0,
    ACT_WEIGHT = 2'd1,
    ACT_COND   = 2'd2,
    ACT_EVAL   = 2'd3
  } action_e;

  localparam logic [1:0] KIND_AND = 2'd1;

  localparam logic [1:0] COND_FREE  = 2'd0;
  localparam logic [1:0] COND_TRUE  = 2'd1;
  localparam logic [1:0] COND_FALSE = 2'd2;
  localparam logic [1:0] COND_BAD   = 2'd3;

  localparam logic CFG_LEAF_COUNT = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  localparam logic [30:0] INF_WEIGHT = 31'h7FFF_FFFF;
  localparam int unsigned MODEL_BITS = 32;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  node_index;
    logic [1:0]  node_kind;
    logic [9:0]  left_child;
    logic [9:0]  right_child;
    logic [5:0]  literal_var;
    logic        literal_negative;
    logic [15:0] weight_value;
    logic [1:0]  condition;
  } in_item_t;

  typedef struct packed {
    logic [30:0] best_weight;
    logic [31:0] model_true_bits;
    logic [31:0] model_set_bits;
  } out_item_t;

  // one stored circuit node
  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] left;
    logic [9:0] right;
    logic [5:0] lit_var;
    logic       neg;
  } node_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_INIT,
    OP_EV_CALC,
    OP_TR_FETCH,
    OP_TR_ACT,
    OP_TR_MARK2,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic eval_last;
    logic cnt_zero;
    logic need_mark2;
    logic out_free;
  } dp_status_t;

endpackage

[sv/dmwe_ifs.sv]
// Handshake channel interfaces of the evaluator
interface dmwe_item_if;
  logic               valid;
  logic               ready;
  dmwe_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface dmwe_result_if;
  logic                valid;
  logic                ready;
  dmwe_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface dmwe_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/dmwe_ctrl.sv]
// Controller state machine: clear pass, loads, bottom-up pass, trace, result handoff
module dmwe_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_is_eval_i,
  input  dmwe_pkg::dp_status_t   status_i,
  output logic                   in_ready_o,
  output dmwe_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [9:0] {
    S_CLR      = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_EV_RD    = 10'b00_0000_0100,
    S_EV_FETCH = 10'b00_0000_1000,
    S_EV_CALC  = 10'b00_0001_0000,
    S_TR_RD    = 10'b00_0010_0000,
    S_TR_FETCH = 10'b00_0100_0000,
    S_TR_ACT   = 10'b00_1000_0000,
    S_TR_MARK2 = 10'b01_0000_0000,
    S_FIN      = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and datapath command
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = dmwe_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLR: begin
        cmd_o.op = dmwe_pkg::OP_CLR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_is_eval_i) begin
            cmd_o.op = dmwe_pkg::OP_INIT;
            state_d  = S_EV_RD;
          end else begin
            cmd_o.op = dmwe_pkg::OP_LOAD;
          end
        end
      end
      S_EV_RD:    state_d = S_EV_FETCH;
      S_EV_FETCH: state_d = S_EV_CALC;
      S_EV_CALC: begin
        cmd_o.op = dmwe_pkg::OP_EV_CALC;
        state_d  = status_i.eval_last ? S_TR_RD : S_EV_RD;
      end
      S_TR_RD:    state_d = S_TR_FETCH;
      S_TR_FETCH: begin
        cmd_o.op = dmwe_pkg::OP_TR_FETCH;
        state_d  = S_TR_ACT;
      end
      S_TR_ACT: begin
        cmd_o.op = dmwe_pkg::OP_TR_ACT;
        if (status_i.need_mark2) state_d = S_TR_MARK2;
        else state_d = status_i.cnt_zero ? S_FIN : S_TR_RD;
      end
      S_TR_MARK2: begin
        cmd_o.op = dmwe_pkg::OP_TR_MARK2;
        state_d  = status_i.cnt_zero ? S_FIN : S_TR_RD;
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.op = dmwe_pkg::OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLR;
    else state_q <= state_d;
  end

endmodule

[sv/dmwe_datapath.sv]
// Datapath: node, weight, choice and mark memories, node counter, result register
module dmwe_datapath #(
  parameter int unsigned MAX_NODES   = 1024,
  parameter int unsigned MAX_VARS    = 32,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dmwe_pkg::dp_cmd_t    cmd_i,
  output dmwe_pkg::dp_status_t status_o,
  input  dmwe_pkg::in_item_t   in_item_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_index_i,
  input  logic [10:0]          cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output dmwe_pkg::out_item_t  out_item_o
);

  localparam int unsigned AW    = $clog2(MAX_NODES);
  localparam int unsigned CW    = $clog2(MAX_NODES + 1);
  localparam int unsigned LW_N  = 2 * (MAX_VARS + 1);
  localparam int unsigned VW    = $clog2(LW_N);
  localparam int unsigned CVW   = $clog2(MAX_VARS + 1);
  localparam int unsigned LW_W  = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

  // storage
  dmwe_pkg::node_t node_mem   [MAX_NODES];
  logic [30:0]     w_mem      [MAX_NODES];
  logic            choice_mem [MAX_NODES];
  logic            mark_mem   [MAX_NODES];
  logic [LW_W-1:0] lw_mem     [LW_N];
  logic [1:0]      cond_mem   [MAX_VARS + 1];
  logic [MAX_VARS:0] cond_vld_q;

  logic [10:0]     leaf_count_q, node_count_q;
  logic [AW-1:0]   cnt_q, n_last_q;
  logic [CW-1:0]   lc_q;
  logic [30:0]     res_w_q;
  logic [31:0]     tbits_q, sbits_q;
  logic            out_valid_q;
  dmwe_pkg::out_item_t out_q;

  // registered read data
  dmwe_pkg::node_t node_rd_q;
  logic [30:0]     wl_q, wr_q;
  logic [LW_W-1:0] lw_q;
  logic [1:0]      cond_rd_q;
  logic            choice_rd_q, mark_rd_q;
  logic            var_ok_q, left_ok_q, right_ok_q;

  // input item decode
  logic [31:0]     in_idx32, in_var32, in_la32, in_w32;
  logic            in_var_ok, in_idx_ok;
  always_comb begin
    in_idx32  = 32'(in_item_i.node_index);
    in_var32  = 32'(in_item_i.literal_var);
    in_la32   = 32'({in_item_i.literal_var, in_item_i.literal_negative});
    in_w32    = 32'(in_item_i.weight_value);
    in_var_ok = in_var32 <= MAX_VARS;
    in_idx_ok = in_idx32 < MAX_NODES;
  end

  logic load_node, load_weight, load_cond;
  assign load_node   = (cmd_i.op == dmwe_pkg::OP_LOAD)
                       && (in_item_i.action == dmwe_pkg::ACT_NODE) && in_idx_ok;
  assign load_weight = (cmd_i.op == dmwe_pkg::OP_LOAD)
                       && (in_item_i.action == dmwe_pkg::ACT_WEIGHT) && in_var_ok;
  assign load_cond   = (cmd_i.op == dmwe_pkg::OP_LOAD)
                       && (in_item_i.action == dmwe_pkg::ACT_COND) && in_var_ok;

  // registered node and child addresses
  logic [31:0]     rd_var32, rd_la32, rd_l32, rd_r32, cnt32;
  always_comb begin
    rd_var32 = 32'(node_rd_q.lit_var);
    rd_la32  = 32'({node_rd_q.lit_var, node_rd_q.neg});
    rd_l32   = 32'(node_rd_q.left);
    rd_r32   = 32'(node_rd_q.right);
    cnt32    = 32'(cnt_q);
  end

  // node evaluation
  logic        is_leaf, is_and;
  logic [30:0] wl, wr, leaf_w, new_w;
  logic [31:0] sum;
  logic        new_choice;
  always_comb begin
    is_leaf    = cnt32 < 32'(lc_q);
    is_and     = node_rd_q.kind == dmwe_pkg::KIND_AND;
    wl         = left_ok_q  ? wl_q : dmwe_pkg::INF_WEIGHT;
    wr         = right_ok_q ? wr_q : dmwe_pkg::INF_WEIGHT;
    sum        = 32'(wl) + 32'(wr);
    new_choice = wr < wl;
    if (!var_ok_q) leaf_w = '0;
    else if ((cond_rd_q == dmwe_pkg::COND_FREE)
             || ((cond_rd_q == dmwe_pkg::COND_TRUE) && !node_rd_q.neg)
             || ((cond_rd_q == dmwe_pkg::COND_FALSE) && node_rd_q.neg)) leaf_w = 31'(lw_q);
    else leaf_w = dmwe_pkg::INF_WEIGHT;
    if (is_leaf) new_w = leaf_w;
    else if (is_and) new_w = (sum >= 32'(dmwe_pkg::INF_WEIGHT)) ? dmwe_pkg::INF_WEIGHT
                                                                : sum[30:0];
    else new_w = new_choice ? wr : wl;
  end

  // trace step
  logic        marked, need_mark2, leaf_var_ok, leaf_val;
  logic [9:0]  pick;
  logic [31:0] var_bit;
  always_comb begin
    marked      = mark_rd_q || (cnt_q == n_last_q);
    need_mark2  = marked && !is_leaf && is_and;
    pick        = (!is_and && choice_rd_q) ? node_rd_q.right : node_rd_q.left;
    leaf_var_ok = (rd_var32 >= 1) && (rd_var32 <= MAX_VARS)
                  && (rd_var32 <= dmwe_pkg::MODEL_BITS);
    leaf_val    = (cond_rd_q == dmwe_pkg::COND_FREE) ? !node_rd_q.neg
                                                     : (cond_rd_q == dmwe_pkg::COND_TRUE);
    var_bit     = 32'd1 << (node_rd_q.lit_var - 6'd1);
  end

  // mark memory write port
  logic          mk_we, mk_wd;
  logic [AW-1:0] mk_addr;
  logic [31:0]   pick32;
  always_comb begin
    pick32  = 32'(pick);
    mk_we   = 1'b0;
    mk_wd   = 1'b0;
    mk_addr = cnt_q;
    case (cmd_i.op)
      dmwe_pkg::OP_CLR, dmwe_pkg::OP_TR_FETCH: mk_we = 1'b1;
      dmwe_pkg::OP_TR_ACT: begin
        mk_we   = marked && !is_leaf && (pick32 < cnt32);
        mk_wd   = 1'b1;
        mk_addr = pick32[AW-1:0];
      end
      dmwe_pkg::OP_TR_MARK2: begin
        mk_we   = rd_r32 < cnt32;
        mk_wd   = 1'b1;
        mk_addr = rd_r32[AW-1:0];
      end
      default: mk_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mk_we) mark_mem[mk_addr] <= mk_wd;
    mark_rd_q <= mark_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (load_node) begin
      node_mem[in_idx32[AW-1:0]] <= '{kind: in_item_i.node_kind,
                                      left: in_item_i.left_child,
                                      right: in_item_i.right_child,
                                      lit_var: in_item_i.literal_var,
                                      neg: in_item_i.literal_negative};
    end
    node_rd_q <= node_mem[cnt_q];
  end

  // node weights: one write, two child reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dmwe_pkg::OP_EV_CALC) w_mem[cnt_q] <= new_w;
    wl_q       <= w_mem[rd_l32[AW-1:0]];
    wr_q       <= w_mem[rd_r32[AW-1:0]];
    left_ok_q  <= rd_l32 < MAX_NODES;
    right_ok_q <= rd_r32 < MAX_NODES;
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == dmwe_pkg::OP_EV_CALC) && !is_leaf && !is_and)
      choice_mem[cnt_q] <= new_choice;
    choice_rd_q <= choice_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (load_weight) lw_mem[in_la32[VW-1:0]] <= in_w32[LW_W-1:0];
    lw_q     <= lw_mem[rd_la32[VW-1:0]];
    var_ok_q <= rd_var32 <= MAX_VARS;
  end

  // conditions: data memory plus valid bits that read as free
  always_ff @(posedge clk_i) begin
    if (load_cond) begin
      cond_mem[in_var32[CVW-1:0]] <= (in_item_i.condition == dmwe_pkg::COND_BAD)
                                     ? dmwe_pkg::COND_FREE : in_item_i.condition;
    end
    cond_rd_q <= ((rd_var32 <= MAX_VARS) && cond_vld_q[rd_var32[CVW-1:0]])
                 ? cond_mem[rd_var32[CVW-1:0]] : dmwe_pkg::COND_FREE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cond_vld_q <= '0;
    else if (load_cond) cond_vld_q[in_var32[CVW-1:0]] <= 1'b1;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= 11'd1;
      node_count_q <= 11'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dmwe_pkg::CFG_LEAF_COUNT: leaf_count_q <= cfg_data_i;
        dmwe_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i;
        default: leaf_count_q <= leaf_count_q;
      endcase
    end
  end

  // clamped counts for a new evaluation
  logic [31:0] n32, lc32;
  always_comb begin
    n32 = 32'(node_count_q);
    if (n32 < 1) n32 = 32'd1;
    if (n32 > MAX_NODES) n32 = MAX_NODES;
    lc32 = 32'(leaf_count_q);
    if (lc32 > n32) lc32 = n32;
  end

  // counter, model vectors and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      n_last_q    <= '0;
      lc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        dmwe_pkg::OP_CLR:  cnt_q <= cnt_q + 1'b1;
        dmwe_pkg::OP_INIT: begin
          cnt_q    <= '0;
          n_last_q <= AW'(n32 - 32'd1);
          lc_q     <= CW'(lc32);
        end
        dmwe_pkg::OP_EV_CALC: begin
          if (cnt_q != n_last_q) cnt_q <= cnt_q + 1'b1;
        end
        dmwe_pkg::OP_TR_ACT: begin
          if (!need_mark2) cnt_q <= cnt_q - 1'b1;
        end
        dmwe_pkg::OP_TR_MARK2: cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
      if (cmd_i.op == dmwe_pkg::OP_RESULT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == dmwe_pkg::OP_EV_CALC) && (cnt_q == n_last_q)) begin
      res_w_q <= new_w;
      tbits_q <= '0;
      sbits_q <= '0;
    end
    if ((cmd_i.op == dmwe_pkg::OP_TR_ACT) && marked && is_leaf && leaf_var_ok) begin
      sbits_q <= sbits_q | var_bit;
      tbits_q <= leaf_val ? (tbits_q | var_bit) : (tbits_q & ~var_bit);
    end
    if (cmd_i.op == dmwe_pkg::OP_RESULT) begin
      out_q <= '{best_weight: res_w_q, model_true_bits: tbits_q, model_set_bits: sbits_q};
    end
  end

  always_comb begin
    status_o.clr_last   = cnt_q == AW'(MAX_NODES - 1);
    status_o.eval_last  = cnt_q == n_last_q;
    status_o.cnt_zero   = cnt_q == '0;
    status_o.need_mark2 = need_mark2;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[sv/dnnf_min_weight_model_evaluator_unit.sv]
// Top level of the minimum-weight model evaluator
// Use: the item channel carries load items (node, literal weight, variable
// condition) and evaluate items; the config channel writes leaf_count (index
// 0) and node_count (index 1) and is always ready; the user must make writes
// go in while idle, as the block itself does not enforce it. Load items are
// taken back to back while idle and give no result. An evaluate item runs a
// bottom-up pass (read, fetch and calculate steps per node), then a top-down
// trace (read, fetch and act steps per node plus a second mark step per
// visited AND node), and gives one result item with the root weight and the
// model vectors; both passes share the single node-table read port.
// The result sits in an output register; while the receiver stalls it holds,
// and load items are still taken; a finished evaluation waits for the slot.
// After reset the block sweeps all MAX_NODES visit marks with item ready
// low; conditions reset to free, counts to one.
module dnnf_min_weight_model_evaluator_unit #(
  parameter int unsigned MAX_NODES   = 1024,
  parameter int unsigned MAX_VARS    = 32,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dmwe_item_if.sink            item_i,
  dmwe_cfg_if.sink             cfg_i,
  dmwe_result_if.source        result_o
);

  dmwe_pkg::dp_cmd_t    cmd;
  dmwe_pkg::dp_status_t status;
  logic                 in_is_eval;

  assign in_is_eval  = item_i.item.action == dmwe_pkg::ACT_EVAL;
  assign cfg_i.ready = 1'b1;

  dmwe_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (item_i.valid),
    .in_is_eval_i (in_is_eval),
    .status_i     (status),
    .in_ready_o   (item_i.ready),
    .cmd_o        (cmd)
  );

  dmwe_datapath #(
    .MAX_NODES   (MAX_NODES),
    .MAX_VARS    (MAX_VARS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (item_i.item),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_item_o  (result_o.item)
  );

endmodule

[sv/dmwe_checker.sv]
// Port checker of the evaluator and its bind to the top level
`include "assert_macros.svh"

module dmwe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [30:0] out_weight_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // an evaluate item makes the block busy
  `DMWE_ASSERT(a_eval_busy, clk_i, rst_ni, (in_acc && (in_action_i == dmwe_pkg::ACT_EVAL)) |=> !in_ready_i)
  // load items never stall the next item
  `DMWE_ASSERT(a_load_ready, clk_i, rst_ni, (in_acc && (in_action_i != dmwe_pkg::ACT_EVAL)) |=> in_ready_i)
  // a new result only comes at the end of an evaluation
  `DMWE_ASSERT(a_result_after_eval, clk_i, rst_ni, $rose(out_valid_i) |-> $past(!in_ready_i))
  // stalled result is kept
  `DMWE_ASSERT(a_out_kept, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i)
  `DMWE_ASSERT_HOLD(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, out_weight_i)

endmodule

bind dnnf_min_weight_model_evaluator_unit dmwe_checker u_dmwe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .in_action_i  (item_i.item.action),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_weight_i (result_o.item.best_weight)
);
